// File: hw/rtl/trace_format_grammar_check_macros.svh
// assertion macros used by the grammar checker rtl
// depends on a clock named clk and an active-low reset named rst_n in the using module
`ifndef TRACE_FORMAT_GRAMMAR_CHECK_MACROS_SVH
`define TRACE_FORMAT_GRAMMAR_CHECK_MACROS_SVH

// same-cycle implication
`define TFGC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TFGC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/tfgc_pkg.sv
// types, character codes and classifier functions for the format grammar checker
// no dependencies
package tfgc_pkg;

  typedef enum logic [3:0] {
    PH_PREFIX      = 4'd0,
    PH_KEY_REST    = 4'd1,
    PH_VALUE_START = 4'd2,
    PH_CONV        = 4'd3,
    PH_STATIC_RUN  = 4'd4,
    PH_AFTER_CONV  = 4'd5,
    PH_SEPARATOR   = 4'd6
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  prefix_pos;
    logic [1:0]  ell_count;
    logic        first_pair;
    logic        rejected;
    logic        terminated;
  } parse_state_t;

  localparam parse_state_t ST_RESET = '{
    phase:      PH_PREFIX,
    prefix_pos: 3'd0,
    ell_count:  2'd0,
    first_pair: 1'b1,
    rejected:   1'b0,
    terminated: 1'b0
  };

  localparam logic [2:0] PREFIX_LAST = 3'd5;
  localparam logic [1:0] ELL_MAX     = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;

  // expected byte at each position of "event="
  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h65;
      3'd1:    c = 8'h76;
      3'd2:    c = 8'h65;
      3'd3:    c = 8'h6e;
      3'd4:    c = 8'h74;
      3'd5:    c = CH_EQ;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_key_char(input logic [7:0] c);
    return is_alpha(c) || (c >= 8'h30 && c <= 8'h39) ||
           c == CH_UNDER || c == CH_DASH || c == CH_DOT;
  endfunction

  function automatic logic is_value_char(input logic [7:0] c);
    return is_key_char(c) || c == CH_COLON;
  endfunction

  function automatic logic is_conv_char(input logic [7:0] c);
    return c == CH_D || c == CH_I || c == CH_U || c == CH_O ||
           c == CH_X_LO || c == CH_X_UP;
  endfunction

  // string may only end after a static run or a full conversion
  function automatic logic end_ok(input phase_t ph);
    return ph == PH_STATIC_RUN || ph == PH_AFTER_CONV;
  endfunction

endpackage

// File: hw/rtl/trace_format_grammar_check.sv
// channel | dir | handshake          | payload
// in_     | in  | in_valid/in_stall  | in_ch[7:0], in_last
// out_    | out | out_valid/out_stall| out_valid_res
//
// one byte per cycle while in_stall is low; a verdict is registered as its last beat advances
// the parser state is updated by one pass of tfgc_step out of the input register
// rst_n is synchronous; the parser restarts at the "event=" prefix after reset
// in_stall rises only when a last beat sits in the input register and a
// verdict still waits in the output register under out_stall
// top level of the format grammar checker; depends on tfgc_pkg, tfgc_step and the macros header
`include "trace_format_grammar_check_macros.svh"

module trace_format_grammar_check (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_valid_res
);

  logic                   s1_valid_r, s1_valid_nxt;
  logic [7:0]             s1_ch_r;
  logic                   s1_last_r;
  logic                   s1_adv;
  logic                   in_take;
  tfgc_pkg::parse_state_t state_r, state_nxt, step_st;
  logic                   step_verdict;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_res_r;

  tfgc_step u_step (
    .st      (state_r),
    .ch      (s1_ch_r),
    .last    (s1_last_r),
    .st_nxt  (step_st),
    .verdict (step_verdict)
  );

  // a non-last beat never needs the output register
  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    state_nxt     = s1_adv ? step_st : state_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (s1_adv && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= tfgc_pkg::ST_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_ch_r   <= in_ch;
      s1_last_r <= in_last;
    end
    if (s1_adv && s1_last_r) begin
      out_res_r <= step_verdict;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = out_res_r;

  `TFGC_ASSERT_NEXT(a_last_gives_verdict, s1_adv && s1_last_r, out_valid_r,
    "last beat did not produce a verdict")
  `TFGC_ASSERT_NEXT(a_restart_after_last, s1_adv && s1_last_r,
    state_r.phase == tfgc_pkg::PH_PREFIX && !state_r.rejected && !state_r.terminated,
    "parser not restarted after last beat")
  `TFGC_ASSERT_NOW(a_term_phase_ok, state_r.terminated && !state_r.rejected,
    state_r.phase == tfgc_pkg::PH_STATIC_RUN || state_r.phase == tfgc_pkg::PH_AFTER_CONV,
    "terminated string accepted in a bad phase")
  `TFGC_ASSERT_NOW(a_stall_needs_full_out, in_stall,
    s1_valid_r && s1_last_r && out_valid_r && out_stall,
    "input stalled without a blocked verdict")

endmodule

// File: hw/rtl/tfgc_step.sv
// next-state function of the grammar parser for one byte, plus end-of-string verdict
// depends on tfgc_pkg
module tfgc_step (
  input  tfgc_pkg::parse_state_t st,
  input  logic [7:0]             ch,
  input  logic                   last,
  output tfgc_pkg::parse_state_t st_nxt,
  output logic                   verdict
);

  tfgc_pkg::parse_state_t work;
  logic                   rej;

  always_comb begin
    work = st;
    rej  = 1'b0;
    if (!st.terminated) begin
      if (ch == tfgc_pkg::CH_NUL) begin
        if (!tfgc_pkg::end_ok(st.phase)) begin
          work.rejected = 1'b1;
        end
        work.terminated = 1'b1;
      end else if (!st.rejected) begin
        unique case (st.phase)
          tfgc_pkg::PH_PREFIX: begin
            if (st.prefix_pos > tfgc_pkg::PREFIX_LAST ||
                ch != tfgc_pkg::prefix_char(st.prefix_pos)) begin
              rej = 1'b1;
            end else if (st.prefix_pos == tfgc_pkg::PREFIX_LAST) begin
              work.prefix_pos = 3'd0;
              work.phase      = tfgc_pkg::PH_VALUE_START;
            end else begin
              work.prefix_pos = st.prefix_pos + 3'd1;
            end
          end
          tfgc_pkg::PH_KEY_REST: begin
            if (ch == tfgc_pkg::CH_EQ) begin
              work.phase = tfgc_pkg::PH_VALUE_START;
            end else if (!tfgc_pkg::is_key_char(ch)) begin
              rej = 1'b1;
            end
          end
          tfgc_pkg::PH_VALUE_START: begin
            if (ch == tfgc_pkg::CH_PCT) begin
              // no conversion in the first pair
              if (st.first_pair) begin
                rej = 1'b1;
              end else begin
                work.ell_count = 2'd0;
                work.phase     = tfgc_pkg::PH_CONV;
              end
            end else if (tfgc_pkg::is_value_char(ch)) begin
              work.phase = tfgc_pkg::PH_STATIC_RUN;
            end else begin
              rej = 1'b1;
            end
          end
          tfgc_pkg::PH_CONV: begin
            if (ch == tfgc_pkg::CH_L && st.ell_count < tfgc_pkg::ELL_MAX) begin
              work.ell_count = st.ell_count + 2'd1;
            end else if (tfgc_pkg::is_conv_char(ch)) begin
              work.phase = tfgc_pkg::PH_AFTER_CONV;
            end else begin
              rej = 1'b1;
            end
          end
          tfgc_pkg::PH_STATIC_RUN: begin
            if (ch == tfgc_pkg::CH_SPACE) begin
              work.phase = tfgc_pkg::PH_SEPARATOR;
            end else if (!tfgc_pkg::is_value_char(ch)) begin
              rej = 1'b1;
            end
          end
          tfgc_pkg::PH_AFTER_CONV: begin
            if (ch == tfgc_pkg::CH_SPACE) begin
              work.phase = tfgc_pkg::PH_SEPARATOR;
            end else begin
              rej = 1'b1;
            end
          end
          tfgc_pkg::PH_SEPARATOR: begin
            if (tfgc_pkg::is_alpha(ch) || ch == tfgc_pkg::CH_UNDER) begin
              work.first_pair = 1'b0;
              work.phase      = tfgc_pkg::PH_KEY_REST;
            end else begin
              rej = 1'b1;
            end
          end
          default: rej = 1'b1;
        endcase
        if (rej) begin
          work.rejected = 1'b1;
        end
      end
    end

    // last beat: close the string if still open, give verdict, start over
    if (last) begin
      if (!work.terminated && !tfgc_pkg::end_ok(work.phase)) begin
        work.rejected = 1'b1;
      end
      verdict = !work.rejected;
      st_nxt  = tfgc_pkg::ST_RESET;
    end else begin
      verdict = 1'b0;
      st_nxt  = work;
    end
  end

endmodule
